### hw/rtl/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

    // Default screen geometry
    localparam int unsigned DEF_COLUMNS = 80;
    localparam int unsigned DEF_ROWS    = 25;

    // One screen cell: attribute byte over character byte
    localparam int unsigned CELL_W = 16;

    // Attribute register value after reset
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    // Characters that start a new line
    localparam logic [7:0] LINE_FEED       = 8'd10;
    localparam logic [7:0] CARRIAGE_RETURN = 8'd13;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    // Engine sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL,
        S_CLEAR,
        S_RESULT
    } t_state;

    // Result of one transaction, engine to output stage
    typedef struct packed {
        logic [10:0] hw_cursor;
        logic [6:0]  column;
        logic [4:0]  row;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
    } t_result;

endpackage

### hw/rtl/tcw_ram.sv
// Generic single write port, single read port RAM with registered read.
module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/tcw_engine.sv
// Cursor state, request sequencer and screen memory sweeps of the text console.
module tcw_engine
    import tcw_pkg::*;
#(
    parameter int unsigned COLS = DEF_COLUMNS,
    parameter int unsigned ROWS = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_attr,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output t_result     o_res
);

    localparam int unsigned N    = COLS * ROWS;
    localparam int unsigned AW   = $clog2(N);
    localparam int unsigned CW   = $clog2(COLS);
    localparam int unsigned RW   = $clog2(ROWS);
    localparam int unsigned CNTW = $clog2(N + 1);

    // Control registers
    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_cnt,   n_cnt;
    logic [CW-1:0]     r_col,   n_col;
    logic [RW-1:0]     r_row,   n_row;
    logic [10:0]       r_shown, n_shown;
    logic              r_rd_use, n_rd_use;

    // Memory port signals
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_wa, ram_ra;
    logic [CELL_W-1:0] ram_wd, ram_rd;

    // Cursor address and new line targets
    logic [AW-1:0]     w_pos;
    logic              w_last_row;
    logic [RW-1:0]     w_nl_row;
    logic [10:0]       w_nl_hw;
    logic              w_is_nl;

    assign w_pos      = AW'(r_row) * AW'(COLS) + AW'(r_col);
    assign w_last_row = (r_row == RW'(ROWS - 1));
    assign w_nl_row   = w_last_row ? r_row : r_row + RW'(1);
    assign w_nl_hw    = 11'(AW'(w_nl_row) * AW'(COLS));
    assign w_is_nl    = (i_char_code == LINE_FEED) || (i_char_code == CARRIAGE_RETURN);

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (N)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    // State and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_shown  <= '0;
            r_rd_use <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_col    <= n_col;
            r_row    <= n_row;
            r_shown  <= n_shown;
            r_rd_use <= n_rd_use;
        end
    end

    // Sequencer: next state, cursor updates and memory accesses
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_col       = r_col;
        n_row       = r_row;
        n_shown     = r_shown;
        n_rd_use    = r_rd_use;
        ram_we      = 1'b0;
        ram_wa      = r_cnt[AW-1:0];
        ram_wd      = '0;
        ram_re      = 1'b0;
        ram_ra      = AW'(i_cell_index);
        o_in_stall  = 1'b1;
        o_res_valid = 1'b0;

        unique case (r_state)
            // Zero the screen after reset
            S_INIT: begin
                ram_we = 1'b1;
                if (r_cnt == CNTW'(N - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CNTW'(1);
                end
            end

            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state  = S_RESULT;
                    n_rd_use = 1'b0;
                    n_cnt    = '0;
                    unique case (t_kind'(i_kind))
                        KIND_WRITE: begin
                            if (!w_is_nl) begin
                                ram_we = 1'b1;
                                ram_wa = w_pos;
                                ram_wd = {i_attr, i_char_code};
                            end
                            if (w_is_nl || r_col == CW'(COLS - 1)) begin
                                n_col   = '0;
                                n_row   = w_nl_row;
                                n_shown = w_nl_hw;
                                if (w_last_row) begin
                                    n_state = S_SCROLL;
                                end
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                        end
                        KIND_DELETE: begin
                            if (r_col != '0) begin
                                n_col  = r_col - CW'(1);
                                ram_we = 1'b1;
                                ram_wa = w_pos - AW'(1);
                                ram_wd = {i_attr, 8'h00};
                            end
                        end
                        KIND_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_shown = '0;
                            n_state = S_CLEAR;
                        end
                        KIND_READ: begin
                            ram_re   = 1'b1;
                            n_rd_use = (32'(i_cell_index) < N);
                        end
                        default: ;
                    endcase
                end
            end

            // Copy rows up one; cell k is written in the cycle after cell k+COLS is read
            S_SCROLL: begin
                ram_re = (r_cnt < CNTW'(N - COLS));
                ram_ra = AW'(r_cnt + CNTW'(COLS));
                ram_we = (r_cnt != '0);
                ram_wa = AW'(r_cnt - CNTW'(1));
                ram_wd = (r_cnt <= CNTW'(N - COLS)) ? ram_rd : '0;
                if (r_cnt == CNTW'(N)) begin
                    n_cnt   = '0;
                    n_state = S_RESULT;
                end else begin
                    n_cnt = r_cnt + CNTW'(1);
                end
            end

            // Clear request: zero every cell
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_cnt == CNTW'(N - 1)) begin
                    n_cnt   = '0;
                    n_state = S_RESULT;
                end else begin
                    n_cnt = r_cnt + CNTW'(1);
                end
            end

            // Hand the result to the output stage
            S_RESULT: begin
                o_res_valid = 1'b1;
                if (!i_res_stall) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result fields; read data stays in the RAM output register until the next read
    assign o_res.hw_cursor = r_shown;
    assign o_res.column    = 7'(r_col);
    assign o_res.row       = 5'(r_row);
    assign o_res.read_char = r_rd_use ? ram_rd[7:0]  : 8'h00;
    assign o_res.read_attr = r_rd_use ? ram_rd[15:8] : 8'h00;

    // Cursor stays on screen
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < COLS) && (32'(r_row) < ROWS))
        else $error("cursor left the screen");

    // No simultaneous read and write of one cell
    a_no_rw_same_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && ram_wa == ram_ra))
        else $error("read and write collide on one cell");

    // A clear request starts the clearing sweep with the cursor homed
    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && t_kind'(i_kind) == KIND_CLEAR) |=>
        (r_state == S_CLEAR && r_col == '0 && r_row == '0 && r_shown == '0))
        else $error("clear did not start its sweep");

    // A stalled result is held
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && i_res_stall) |=> (r_state == S_RESULT && $stable(o_res)))
        else $error("result changed while held");

endmodule

### hw/rtl/text_console_writer.sv
// Top level of the text console writer: attribute register, engine and output register.
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_stall   i_kind, i_char_code, i_cell_index
//  out      from block o_out_valid / i_out_stall o_hw_cursor, o_column, o_row,
//                                                o_read_char, o_read_attr
//  cfg      to block   i_cfg_wr_en               i_cfg_wr_data (text attribute)
//
// Write, delete and read do the cell memory access, then give the result.
// A new line on the last row sweeps the cell memory once, as does clear.
// After reset the cell memory is zeroed with o_in_stall high; configuration
// writes are taken throughout.
// The output register lets the next transaction start while a result is stalled.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int unsigned SCREEN_COLUMNS = DEF_COLUMNS,
    parameter int unsigned SCREEN_ROWS    = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_hw_cursor,
    output logic [6:0]  o_column,
    output logic [4:0]  o_row,
    output logic [7:0]  o_read_char,
    output logic [7:0]  o_read_attr
);

    logic [7:0] r_attr;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic       res_valid;
    logic       res_stall;

    // Attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    tcw_engine #(
        .COLS (SCREEN_COLUMNS),
        .ROWS (SCREEN_ROWS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attr       (r_attr),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .o_res        (res)
    );

    // Output register is free when empty or being taken
    assign res_stall = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && !res_stall) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && !res_stall) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hw_cursor = r_out.hw_cursor;
    assign o_column    = r_out.column;
    assign o_row       = r_out.row;
    assign o_read_char = r_out.read_char;
    assign o_read_attr = r_out.read_attr;

endmodule

### bench/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: driver, monitor and console predictor.
module tb_text_console_writer
    import tcw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COLS  = DEF_COLUMNS;
    localparam int unsigned ROWS  = DEF_ROWS;
    localparam int unsigned CELLS = COLS * ROWS;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES    = 2100;

    // One console request as driven on the input channel
    typedef struct {
        t_kind       kind;
        logic [7:0]  code;
        logic [10:0] index;
    } t_console_req;

    // Block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = KIND_WRITE;
    logic [7:0]  i_char_code = 8'h00;
    logic [10:0] i_cell_index = 11'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [10:0] o_hw_cursor;
    logic [6:0]  o_column;
    logic [4:0]  o_row;
    logic [7:0]  o_read_char;
    logic [7:0]  o_read_attr;

    // Pending requests and expected console status
    t_console_req pending_q[$];
    t_result      expected_status_q[$];
    t_console_req next_req;
    t_result      got_status;
    t_result      want_status;

    // Console shadow state
    logic [15:0] screen_m [CELLS];
    logic [6:0]  cur_col_m;
    logic [4:0]  cur_row_m;
    logic [10:0] shown_m;
    logic [7:0]  text_attr_m;

    // Handshake and idling control
    logic in_taken = 1'b0;
    bit   idle_on = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   free_left = 0;
    int   hold_left = 0;
    int   pressure_asks = 0;
    int   pressure_seen = 0;
    int   error_count = 0;

    text_console_writer #(
        .SCREEN_COLUMNS(COLS),
        .SCREEN_ROWS   (ROWS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hw_cursor  (o_hw_cursor),
        .o_column     (o_column),
        .o_row        (o_row),
        .o_read_char  (o_read_char),
        .o_read_attr  (o_read_attr)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 100);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Zero all cells and home the cursor
    function automatic void wipe_screen();
        for (int i = 0; i < CELLS; i++) screen_m[i] = 16'h0000;
        cur_col_m = '0;
        cur_row_m = '0;
        shown_m   = '0;
    endfunction

    // Column 0, next row; scroll up one row when already on the bottom row
    function automatic void start_new_line();
        cur_col_m = '0;
        if (cur_row_m == ROWS - 1) begin
            for (int i = 0; i < CELLS - COLS; i++) screen_m[i] = screen_m[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen_m[i] = 16'h0000;
        end else begin
            cur_row_m++;
        end
        shown_m = 11'(cur_row_m * COLS + cur_col_m);
    endfunction

    // Apply one request to the shadow console and return the status it reports
    function automatic t_result apply_request(t_kind kind, logic [7:0] code,
                                              logic [10:0] index);
        t_result     r;
        logic [10:0] pos;
        r   = '0;
        pos = 11'(cur_row_m * COLS + cur_col_m);
        case (kind)
            KIND_WRITE: begin
                if (code == LINE_FEED || code == CARRIAGE_RETURN) begin
                    start_new_line();
                end else begin
                    screen_m[pos] = {text_attr_m, code};
                    cur_col_m++;
                    if (cur_col_m >= COLS) start_new_line();
                end
            end
            KIND_DELETE: begin
                // nothing to do at column zero
                if (cur_col_m != 0) begin
                    cur_col_m--;
                    screen_m[pos - 11'd1] = {text_attr_m, 8'h00};
                end
            end
            KIND_CLEAR: begin
                wipe_screen();
            end
            default: begin
                if (index < CELLS) begin
                    r.read_char = screen_m[index][7:0];
                    r.read_attr = screen_m[index][15:8];
                end
            end
        endcase
        r.hw_cursor = shown_m;
        r.column    = cur_col_m;
        r.row       = cur_row_m;
        return r;
    endfunction

    // Request driver: one transaction at a time, held while stalled
    always @(negedge i_clk) begin
        if (i_in_valid && !in_taken) begin
            // stalled: payload stays put
        end else if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            i_in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
            next_req = pending_q.pop_front();
            i_kind       <= next_req.kind;
            i_char_code  <= next_req.code;
            i_cell_index <= next_req.index;
            i_in_valid   <= 1'b1;
            gap_left     <= idle_on ? pick_idle() : 0;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result side back-pressure: random stalls plus the long hold-off on request
    always @(negedge i_clk) begin
        if (pressure_seen != pressure_asks) begin
            pressure_seen <= pressure_asks;
            hold_left     <= HOLD_OFF_CYCLES - 1;
            i_out_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left   <= free_left - 1;
            i_out_stall <= 1'b0;
        end else begin
            free_left   <= $urandom_range(0, 12);
            stall_left  <= pick_idle();
            i_out_stall <= 1'b0;
        end
    end

    // Accepted requests feed the predictor; accepted results are checked in order
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_status_q.push_back(apply_request(t_kind'(i_kind), i_char_code,
                                                      i_cell_index));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_status = '{o_hw_cursor, o_column, o_row, o_read_char, o_read_attr};
            if (expected_status_q.size() == 0) begin
                note_error($sformatf("unexpected result cur=%0d col=%0d row=%0d chr=%02h attr=%02h",
                    o_hw_cursor, o_column, o_row, o_read_char, o_read_attr));
            end else begin
                want_status = expected_status_q.pop_front();
                if (got_status.hw_cursor !== want_status.hw_cursor ||
                    got_status.column    !== want_status.column    ||
                    got_status.row       !== want_status.row       ||
                    got_status.read_char !== want_status.read_char ||
                    got_status.read_attr !== want_status.read_attr)
                    note_error($sformatf({"expected cur=%0d col=%0d row=%0d chr=%02h attr=%02h",
                        ", got cur=%0d col=%0d row=%0d chr=%02h attr=%02h"},
                        want_status.hw_cursor, want_status.column, want_status.row,
                        want_status.read_char, want_status.read_attr,
                        got_status.hw_cursor, got_status.column, got_status.row,
                        got_status.read_char, got_status.read_attr));
            end
        end
    end

    function automatic void push_req(t_kind kind, logic [7:0] code, logic [10:0] index);
        t_console_req req;
        req.kind  = kind;
        req.code  = code;
        req.index = index;
        pending_q.push_back(req);
    endfunction

    // Read address: mostly where text tends to sit, sometimes past the screen
    function automatic logic [10:0] pick_cell();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 11'($urandom_range(0, 399));
        if (r < 70) return 11'($urandom_range(CELLS - 400, CELLS - 1));
        if (r < 85) return 11'($urandom_range(0, CELLS - 1));
        return 11'($urandom_range(CELLS, 2047));
    endfunction

    // Random traffic built from text lines, new lines, reads, deletes and noise
    task automatic fill_random(input int n_items);
        int start_size;
        int r;
        int len;
        start_size = pending_q.size();
        while (pending_q.size() - start_size < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                // a line of text, sometimes long enough to wrap
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 20)
                                                   : $urandom_range(70, 90);
                for (int i = 0; i < len; i++)
                    push_req(KIND_WRITE, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
                if ($urandom_range(0, 3) != 0)
                    push_req(KIND_WRITE, $urandom_range(0, 1) ? LINE_FEED : CARRIAGE_RETURN,
                             11'($urandom_range(0, 2047)));
            end else if (r < 60) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    push_req(KIND_WRITE, $urandom_range(0, 1) ? LINE_FEED : CARRIAGE_RETURN,
                             11'($urandom_range(0, 2047)));
            end else if (r < 78) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    push_req(KIND_READ, 8'($urandom_range(0, 255)), pick_cell());
            end else if (r < 90) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    push_req(KIND_DELETE, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            end else if (r < 99) begin
                // noise: any kind, any fields
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    push_req(t_kind'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
            end else begin
                push_req(KIND_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || i_in_valid || expected_status_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Attribute register write, only with the block idle
    task automatic write_attribute(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        text_attr_m = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Run limit
    initial begin
        #1_000_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Sequence: reset, directed requests, then random phases under several attributes
    initial begin
        logic [7:0] attr_plan [8];
        wipe_screen();
        text_attr_m = ATTR_RESET;
        attr_plan = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'hA5,
                      8'($urandom_range(0, 255)), 8'h5A, 8'($urandom_range(0, 255)), ATTR_RESET};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, new line codes, delete at column zero, clear, reads past the end
        idle_on = 1'b0;
        push_req(KIND_READ,   8'h00, 11'd0);
        push_req(KIND_WRITE,  8'h00, 11'd2047);
        push_req(KIND_WRITE,  8'hFF, 11'd0);
        push_req(KIND_READ,   8'hFF, 11'd0);
        push_req(KIND_READ,   8'h00, 11'd1);
        push_req(KIND_DELETE, 8'h00, 11'd0);
        push_req(KIND_READ,   8'h00, 11'd1);
        push_req(KIND_WRITE,  LINE_FEED, 11'd0);
        push_req(KIND_DELETE, 8'hFF, 11'd2047);
        push_req(KIND_WRITE,  CARRIAGE_RETURN, 11'd0);
        push_req(KIND_WRITE,  8'h7F, 11'd0);
        push_req(KIND_READ,   8'h00, 11'd160);
        push_req(KIND_READ,   8'h00, 11'd2047);
        push_req(KIND_READ,   8'h00, 11'(CELLS));
        push_req(KIND_READ,   8'h00, 11'(CELLS - 1));
        push_req(KIND_CLEAR,  8'h00, 11'd0);
        push_req(KIND_READ,   8'h00, 11'd0);
        push_req(KIND_WRITE,  8'h55, 11'd0);
        push_req(KIND_WRITE,  8'hAA, 11'd0);
        push_req(KIND_DELETE, 8'h00, 11'd0);
        push_req(KIND_DELETE, 8'h00, 11'd0);
        push_req(KIND_DELETE, 8'h00, 11'd0);
        push_req(KIND_WRITE,  LINE_FEED, 11'd0);
        wait_drained();

        // random phases; two without idling, one of them with the long result hold-off
        for (int p = 0; p < 8; p++) begin
            write_attribute(attr_plan[p]);
            idle_on = !(p == 1 || p == 3);
            fill_random(230);
            if (p == 3) pressure_asks++;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_status_q.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_status_q.size()));
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
